/* rtl/core/rsl_pkg.sv */
package rsl_pkg;

    localparam int LABELS     = 1024;
    localparam int COUNT_BITS = 22;
    localparam int ADDR_W     = $clog2(LABELS);
    localparam int LBL_W      = 11;
    localparam int ELEV_W     = 16;
    localparam int COV_W      = 8;
    localparam int THR_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SUM_W      = COUNT_BITS + ELEV_W;
    localparam int Q4_W       = 26;
    localparam int PROD_W     = Q4_W + COV_W + 1;
    localparam int DIV_MAG_W  = SUM_W + 4;
    localparam int DIV_STEPS  = 23;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int QUOT_W     = DIV_STEPS + 1;

    // coverage weight: x / 255 as (x * ceil(2^39 / 255)) >> 39, exact for x < 2^30
    localparam int COV_MAG_W  = 30;
    localparam int COV_RCP_W  = 32;
    localparam logic [COV_RCP_W-1:0] COV_RCP = 32'h8080_8081;
    localparam int COV_SHIFT  = 39;
    localparam int COV_PROD_W = COV_MAG_W + COV_RCP_W;
    localparam int COV_Q_W    = COV_PROD_W - COV_SHIFT;

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_ACC    = 2'd0;
    localparam t_cmd CMD_FLAT   = 2'd1;
    localparam t_cmd CMD_CLR    = 2'd2;
    localparam t_cmd CMD_UNUSED = 2'd3;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_KEEP  = 2'd0;
    localparam t_kind KIND_OCEAN = 2'd1;
    localparam t_kind KIND_LAKE  = 2'd2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_OCEAN  = 2'd0;
    localparam t_cfg_idx CFG_THR    = 2'd1;
    localparam t_cfg_idx CFG_CARVE  = 2'd2;
    localparam t_cfg_idx CFG_USECOV = 2'd3;

    typedef struct packed {
        logic [COUNT_BITS-1:0]   cnt;
        logic signed [SUM_W-1:0] sum;
        logic signed [ELEV_W-1:0] mn;
    } t_stat;

    typedef struct packed {
        t_stat area;
        t_stat outline;
    } t_entry;

    localparam t_stat STAT_EMPTY = '{cnt: '0, sum: '0, mn: 16'sh7FFF};
    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_cmd                      cmd;
        logic signed [LBL_W-1:0]   label;
        logic signed [LBL_W-1:0]   left_label;
        logic signed [LBL_W-1:0]   right_label;
        logic signed [LBL_W-1:0]   up_label;
        logic signed [LBL_W-1:0]   down_label;
        logic                      on_border;
        logic signed [ELEV_W-1:0]  elevation;
        logic [COV_W-1:0]          coverage;
    } t_in_word;

    typedef struct packed {
        logic signed [ELEV_W-1:0] out_elevation;
        t_kind                    pixel_kind;
        logic signed [ELEV_W-1:0] lake_level;
    } t_out_word;

    typedef enum logic [4:0] {
        OP_NONE, OP_SWEEP, OP_LOAD, OP_READ, OP_DECIDE,
        OP_START_AVG, OP_TAKE_AVG, OP_START_OAVG, OP_TAKE_OAVG,
        OP_LVL_A, OP_LVL_B, OP_DIFF, OP_MUL, OP_START_COV, OP_TAKE_COV,
        OP_FIN, OP_OUT
    } t_op;

    typedef struct packed {
        logic sweep_last;
        logic flat;
        logic outline_nz;
        logic div_done;
        logic use_cov;
        logic out_hold;
    } t_dp_status;

endpackage

/* rtl/core/rsl_in_if.sv */
interface rsl_in_if;
    import rsl_pkg::*;
    logic                     valid;
    logic                     ready;
    t_cmd                     cmd;
    logic signed [LBL_W-1:0]  label;
    logic signed [LBL_W-1:0]  left_label;
    logic signed [LBL_W-1:0]  right_label;
    logic signed [LBL_W-1:0]  up_label;
    logic signed [LBL_W-1:0]  down_label;
    logic                     on_border;
    logic signed [ELEV_W-1:0] elevation;
    logic [COV_W-1:0]         coverage;

    modport source (output valid, cmd, label, left_label, right_label, up_label,
                    down_label, on_border, elevation, coverage, input ready);
    modport sink   (input valid, cmd, label, left_label, right_label, up_label,
                    down_label, on_border, elevation, coverage, output ready);
endinterface

/* rtl/core/rsl_out_if.sv */
interface rsl_out_if;
    import rsl_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [ELEV_W-1:0] out_elevation;
    t_kind                    pixel_kind;
    logic signed [ELEV_W-1:0] lake_level;

    modport source (output valid, out_elevation, pixel_kind, lake_level, input ready);
    modport sink   (input valid, out_elevation, pixel_kind, lake_level, output ready);
endinterface

/* rtl/core/rsl_ram.sv */
module rsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/rsl_div.sv */
module rsl_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [rsl_pkg::DIV_MAG_W-1:0]      i_mag,
    input  logic                               i_neg,
    input  logic [rsl_pkg::COUNT_BITS-1:0]     i_den,
    output logic                               o_done,
    output logic signed [rsl_pkg::QUOT_W-1:0]  o_quot
);
    import rsl_pkg::*;

    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_den;
    logic [DIV_STEPS-1:0]  r_sh;
    logic [DIV_STEPS-1:0]  r_q;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic                  r_neg;

    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   trial_sub;
    logic                  ge;
    logic signed [QUOT_W-1:0] q_pos;

    // the quotient is known to fit in DIV_STEPS bits, so the upper dividend
    // bits start out as a partial remainder below the divisor
    always_comb begin
        trial     = {r_rem, r_sh[DIV_STEPS-1]};
        ge        = trial >= {1'b0, r_den};
        trial_sub = trial - {1'b0, r_den};
        q_pos     = $signed({1'b0, r_q});
        o_quot    = r_neg ? -q_pos : q_pos;
        o_done    = r_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= COUNT_BITS'(i_mag[DIV_MAG_W-1:DIV_STEPS]);
            r_sh  <= i_mag[DIV_STEPS-1:0];
            r_den <= i_den;
            r_neg <= i_neg;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? trial_sub[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            r_sh  <= {r_sh[DIV_STEPS-2:0], 1'b0};
            r_q   <= {r_q[DIV_STEPS-2:0], ge};
        end
    end
endmodule

/* rtl/core/rsl_dp.sv */
module rsl_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rsl_pkg::t_op                    i_op,
    output rsl_pkg::t_dp_status             o_status,
    input  logic                            i_cfg_we,
    input  logic [rsl_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rsl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  rsl_pkg::t_in_word               i_in_word,
    output rsl_pkg::t_out_word              o_out_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready
);
    import rsl_pkg::*;

    logic signed [ELEV_W-1:0] r_ocean;
    logic [THR_W-1:0]         r_thr;
    logic [THR_W-1:0]         r_carve;
    logic                     r_use_cov;

    t_in_word                 r_in;
    t_entry                   r_ent;
    logic [ADDR_W-1:0]        r_sweep;
    logic signed [Q4_W-1:0]   r_avg, r_oavg, r_omin, r_el, r_lim, r_diff, r_adj;
    logic signed [PROD_W-1:0] r_prod;
    logic [COV_Q_W-1:0]       r_cov_q;
    logic                     r_cov_neg;
    logic signed [ELEV_W-1:0] r_res, r_level;
    t_kind                    r_kind;
    t_out_word                r_out;
    logic                     r_out_valid;

    logic                     lab_valid, is_edge, acc_we, clr_we, ram_we;
    logic [ADDR_W-1:0]        addr, waddr;
    t_entry                   rdata, wdata;
    t_stat                    dstat;
    logic [SUM_W-1:0]         smag;
    logic signed [PROD_W-1:0] pmag;
    logic [COV_PROD_W-1:0]    cov_prod;
    logic                     div_start, div_done;
    logic [DIV_MAG_W-1:0]     div_mag;
    logic                     div_neg;
    logic [COUNT_BITS-1:0]    div_den;
    logic signed [QUOT_W-1:0] quot;
    logic signed [Q4_W-1:0]   thr16, thr8, carve16, elev16, d, q34, el_b;
    logic signed [Q4_W:0]     nq;

    function automatic t_stat add_sample(t_stat s, logic signed [ELEV_W-1:0] e);
        t_stat r;
        r = s;
        if (s.cnt != {COUNT_BITS{1'b1}}) begin
            r.cnt = s.cnt + 1'b1;
            r.sum = s.sum + SUM_W'(e);
        end
        if (e < s.mn) begin
            r.mn = e;
        end
        return r;
    endfunction

    function automatic logic signed [Q4_W-1:0] to_q4(logic signed [ELEV_W-1:0] x);
        return {{(Q4_W-ELEV_W-4){x[ELEV_W-1]}}, x, 4'b0000};
    endfunction

    // divide by 16 toward zero, then clamp to 16 bits
    function automatic logic signed [ELEV_W-1:0] q4_to_int(logic signed [Q4_W:0] v);
        logic signed [Q4_W:0] t;
        t = v[Q4_W] ? ((v + (Q4_W+1)'(15)) >>> 4) : (v >>> 4);
        if (t > (Q4_W+1)'(32767)) begin
            return 16'sh7FFF;
        end else if (t < -(Q4_W+1)'(32768)) begin
            return 16'sh8000;
        end
        return t[ELEV_W-1:0];
    endfunction

    always_comb begin
        lab_valid = !r_in.label[LBL_W-1] && (r_in.label != '0) &&
                    ({{(32-LBL_W){1'b0}}, r_in.label} < 32'(LABELS));
        is_edge   = (r_in.left_label != r_in.label) || (r_in.right_label != r_in.label) ||
                    (r_in.up_label != r_in.label) || (r_in.down_label != r_in.label);
        addr      = r_in.label[ADDR_W-1:0];
        acc_we    = (i_op == OP_DECIDE) && (r_in.cmd == CMD_ACC) && lab_valid &&
                    !r_in.on_border;
        clr_we    = (i_op == OP_DECIDE) && (r_in.cmd == CMD_CLR) && lab_valid;
        ram_we    = (i_op == OP_SWEEP) || acc_we || clr_we;
        waddr     = (i_op == OP_SWEEP) ? r_sweep : addr;
        if (acc_we) begin
            wdata.area    = add_sample(rdata.area, r_in.elevation);
            wdata.outline = is_edge ? add_sample(rdata.outline, r_in.elevation)
                                    : rdata.outline;
        end else begin
            wdata.area    = STAT_EMPTY;
            wdata.outline = STAT_EMPTY;
        end

        dstat     = (i_op == OP_START_AVG) ? r_ent.area : r_ent.outline;
        smag      = dstat.sum[SUM_W-1] ? -dstat.sum : dstat.sum;
        pmag      = r_prod[PROD_W-1] ? -r_prod : r_prod;
        div_start = (i_op == OP_START_AVG) || (i_op == OP_START_OAVG);
        div_mag   = {smag, 4'b0000};
        div_neg   = dstat.sum[SUM_W-1];
        div_den   = dstat.cnt;
        cov_prod  = pmag[COV_MAG_W-1:0] * COV_RCP;

        thr16   = {{(Q4_W-THR_W-4){1'b0}}, r_thr, 4'b0000};
        thr8    = {{(Q4_W-THR_W-3){1'b0}}, r_thr, 3'b000};
        carve16 = {{(Q4_W-THR_W-4){1'b0}}, r_carve, 4'b0000};
        elev16  = to_q4(r_in.elevation);
        d       = r_avg - r_el;
        q34     = (d + (d <<< 1)) >>> 2;
        el_b    = (r_el < r_lim) ? (r_oavg - thr8) : (r_el + ((thr8 < q34) ? thr8 : q34));
        nq      = (Q4_W+1)'(elev16) + (Q4_W+1)'(r_adj);

        o_status.sweep_last = (r_sweep == ADDR_W'(LABELS - 1));
        o_status.flat       = (r_in.cmd == CMD_FLAT) && lab_valid && (rdata.area.cnt != '0);
        o_status.outline_nz = (r_ent.outline.cnt != '0);
        o_status.div_done   = div_done;
        o_status.use_cov    = r_use_cov;
        o_status.out_hold   = r_out_valid && !i_out_ready;
    end

    rsl_ram #(.WIDTH(ENTRY_W), .DEPTH(LABELS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_op == OP_READ),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    rsl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (div_mag),
        .i_neg   (div_neg),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocean     <= '0;
            r_thr       <= THR_W'(50);
            r_carve     <= '0;
            r_use_cov   <= 1'b0;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_OCEAN:  r_ocean   <= i_cfg_data;
                    CFG_THR:    r_thr     <= i_cfg_data[THR_W-1:0];
                    CFG_CARVE:  r_carve   <= i_cfg_data[THR_W-1:0];
                    CFG_USECOV: r_use_cov <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_op == OP_SWEEP) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (i_op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: r_in <= i_in_word;
            OP_DECIDE: begin
                r_ent   <= rdata;
                r_level <= '0;
                if ((r_in.cmd == CMD_FLAT) && r_in.label[LBL_W-1]) begin
                    r_res  <= r_ocean;
                    r_kind <= KIND_OCEAN;
                end else begin
                    r_res  <= r_in.elevation;
                    r_kind <= KIND_KEEP;
                end
            end
            OP_TAKE_AVG: begin
                r_avg <= Q4_W'(quot);
                if (r_ent.outline.cnt == '0) begin
                    r_oavg <= Q4_W'(quot);
                    r_omin <= to_q4(r_ent.area.mn);
                end else begin
                    r_omin <= to_q4(r_ent.outline.mn);
                end
            end
            OP_TAKE_OAVG: r_oavg <= Q4_W'(quot);
            OP_LVL_A: begin
                r_el  <= (r_omin < r_avg) ? r_omin : r_avg;
                r_lim <= r_oavg - thr16;
            end
            OP_LVL_B: r_el <= el_b;
            OP_DIFF: begin
                r_diff <= r_el - carve16 - elev16;
                r_adj  <= r_el - carve16 - elev16;
            end
            OP_MUL:      r_prod <= r_diff * $signed({1'b0, r_in.coverage});
            OP_START_COV: begin
                r_cov_q   <= cov_prod[COV_PROD_W-1:COV_SHIFT];
                r_cov_neg <= r_prod[PROD_W-1];
            end
            OP_TAKE_COV: begin
                r_adj <= r_cov_neg ? -$signed({{(Q4_W-COV_Q_W){1'b0}}, r_cov_q})
                                   : $signed({{(Q4_W-COV_Q_W){1'b0}}, r_cov_q});
            end
            OP_FIN: begin
                r_res   <= q4_to_int(nq);
                r_level <= q4_to_int((Q4_W+1)'(r_el));
                r_kind  <= KIND_LAKE;
            end
            OP_OUT: begin
                r_out.out_elevation <= r_res;
                r_out.pixel_kind    <= r_kind;
                r_out.lake_level    <= r_level;
            end
            default: ;
        endcase
    end

    assign o_out_word  = r_out;
    assign o_out_valid = r_out_valid;
endmodule

/* rtl/core/rsl_ctrl.sv */
module rsl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  rsl_pkg::t_dp_status  i_status,
    output logic                 o_in_ready,
    output rsl_pkg::t_op         o_op
);
    import rsl_pkg::*;

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_READ, S_DECIDE, S_AVG0, S_AVG, S_OAVG0, S_OAVG,
        S_LVLA, S_LVLB, S_DIFF, S_MUL, S_COV0, S_COV, S_FIN, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_SWEEP: begin
                o_op = OP_SWEEP;
                if (i_status.sweep_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_op    = OP_READ;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_op    = OP_DECIDE;
                n_state = i_status.flat ? S_AVG0 : S_DONE;
            end
            S_AVG0: begin
                o_op    = OP_START_AVG;
                n_state = S_AVG;
            end
            S_AVG: begin
                if (i_status.div_done) begin
                    o_op    = OP_TAKE_AVG;
                    n_state = i_status.outline_nz ? S_OAVG0 : S_LVLA;
                end
            end
            S_OAVG0: begin
                o_op    = OP_START_OAVG;
                n_state = S_OAVG;
            end
            S_OAVG: begin
                if (i_status.div_done) begin
                    o_op    = OP_TAKE_OAVG;
                    n_state = S_LVLA;
                end
            end
            S_LVLA: begin
                o_op    = OP_LVL_A;
                n_state = S_LVLB;
            end
            S_LVLB: begin
                o_op    = OP_LVL_B;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                o_op    = OP_DIFF;
                n_state = i_status.use_cov ? S_MUL : S_FIN;
            end
            S_MUL: begin
                o_op    = OP_MUL;
                n_state = S_COV0;
            end
            S_COV0: begin
                o_op    = OP_START_COV;
                n_state = S_COV;
            end
            S_COV: begin
                o_op    = OP_TAKE_COV;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_op    = OP_FIN;
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register frees up
                if (!i_status.out_hold) begin
                    o_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_SWEEP;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;
endmodule

/* rtl/core/region_stats_lake_flattener_core.sv */
// Accumulate, clear and pass-through words go through the read, decide and output states;
// a lake flatten word also waits on the 23-step divider, run for the area mean and,
// when the outline is not empty, for the outline mean, before the level steps.
// One word is in work at a time; a finished result waits in the output register.
// After reset a clearing pass over all 1024 label entries empties the label table before
// the first word is accepted; configuration writes are taken at any time.
module region_stats_lake_flattener_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rsl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rsl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rsl_in_if.sink                         i_in,
    rsl_out_if.source                      o_out
);
    import rsl_pkg::*;

    t_op        op;
    t_dp_status status;
    t_in_word   in_word;
    t_out_word  out_word;
    logic       in_ready;
    logic       out_valid;

    assign in_word = '{cmd: i_in.cmd, label: i_in.label, left_label: i_in.left_label,
                       right_label: i_in.right_label, up_label: i_in.up_label,
                       down_label: i_in.down_label, on_border: i_in.on_border,
                       elevation: i_in.elevation, coverage: i_in.coverage};

    assign i_in.ready          = in_ready;
    assign o_out.valid         = out_valid;
    assign o_out.out_elevation = out_word.out_elevation;
    assign o_out.pixel_kind    = out_word.pixel_kind;
    assign o_out.lake_level    = out_word.lake_level;

    rsl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_op       (op)
    );

    rsl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_word   (in_word),
        .o_out_word  (out_word),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready)
    );
endmodule
